/* rtl/core/stt_pkg.sv */
// Shared types and constants for the source text tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int TOKEN_FIFO_DEPTH      = 4;

    typedef enum logic [2:0] {
        KIND_IDENT  = 3'd0,
        KIND_NUMBER = 3'd1,
        KIND_SYMBOL = 3'd2,
        KIND_FUNC   = 3'd3,
        KIND_END    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2
    } mode_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
        logic        last;
    } token_t;

    // Tokens produced by one byte, slot 0 first; count is 0, 1 or 2.
    typedef struct packed {
        token_t     tok0;
        token_t     tok1;
        logic [1:0] count;
    } scan_out_t;

endpackage

`default_nettype wire

/* rtl/core/stt_scan.sv */
// Scanner state and per-byte token formation.
`timescale 1ns / 1ps
`default_nettype none

module stt_scan #(
    parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              proc_en,
    input  wire logic [7:0]        text_byte,
    output stt_pkg::scan_out_t     result
);

    localparam int POS_W = (POSITION_BITS < 16) ? POSITION_BITS : 16;

    localparam logic [2:0] KW_NONE = 3'd0;
    localparam logic [2:0] KW_F    = 3'd1;
    localparam logic [2:0] KW_FU   = 3'd2;
    localparam logic [2:0] KW_FUN  = 3'd3;
    localparam logic [2:0] KW_FUNC = 3'd4;
    localparam logic [2:0] KW_DEAD = 3'd7;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [2:0] kw_step(input logic [2:0] prog, input logic [7:0] c);
        if (prog == KW_F && c == 8'h75)
            return KW_FU;
        if (prog == KW_FU && c == 8'h6E)
            return KW_FUN;
        if (prog == KW_FUN && c == 8'h63)
            return KW_FUNC;
        return KW_DEAD;
    endfunction

    stt_pkg::mode_t mode_reg, mode_next;
    logic [POS_W-1:0] word_start_reg, word_start_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      line_reg, line_next;
    logic [15:0]      word_len_reg, word_len_next;
    logic [2:0]       kw_reg, kw_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= stt_pkg::MODE_IDLE;
            word_start_reg <= '0;
            pos_reg        <= '0;
            line_reg       <= 16'd1;
            word_len_reg   <= '0;
            kw_reg         <= KW_NONE;
        end
        else if (proc_en)
        begin
            mode_reg       <= mode_next;
            word_start_reg <= word_start_next;
            pos_reg        <= pos_next;
            line_reg       <= line_next;
            word_len_reg   <= word_len_next;
            kw_reg         <= kw_next;
        end
    end

    logic           cont;
    logic           have_word;
    stt_pkg::token_t word_tok;
    stt_pkg::token_t char_tok;
    logic           have_char;
    logic [POS_W-1:0] pos_inc;

    always_comb
    begin
        mode_next       = mode_reg;
        word_start_next = word_start_reg;
        line_next       = line_reg;
        word_len_next   = word_len_reg;
        kw_next         = kw_reg;
        pos_inc         = (pos_reg != {POS_W{1'b1}}) ? pos_reg + POS_W'(1) : pos_reg;
        pos_next        = pos_inc;

        case (mode_reg)
            stt_pkg::MODE_IDENT:  cont = is_letter(text_byte) || is_digit(text_byte)
                                         || text_byte == CH_UNDER;
            stt_pkg::MODE_NUMBER: cont = is_digit(text_byte);
            default:              cont = 1'b0;
        endcase

        have_word       = (mode_reg != stt_pkg::MODE_IDLE) && !cont;
        word_tok.kind   = (mode_reg == stt_pkg::MODE_NUMBER) ? stt_pkg::KIND_NUMBER
                        : (kw_reg == KW_FUNC) ? stt_pkg::KIND_FUNC : stt_pkg::KIND_IDENT;
        word_tok.start  = 16'(word_start_reg);
        word_tok.length = word_len_reg;
        word_tok.line   = line_reg;
        word_tok.last   = 1'b0;

        have_char       = 1'b0;
        char_tok.kind   = stt_pkg::KIND_SYMBOL;
        char_tok.start  = 16'(pos_reg);
        char_tok.length = 16'd1;
        char_tok.line   = line_reg;
        char_tok.last   = 1'b1;

        if (cont)
        begin
            if (word_len_reg != 16'hFFFF)
                word_len_next = word_len_reg + 16'd1;
            if (mode_reg == stt_pkg::MODE_IDENT)
                kw_next = kw_step(kw_reg, text_byte);
        end
        else
        begin
            mode_next     = stt_pkg::MODE_IDLE;
            kw_next       = KW_NONE;
            word_len_next = '0;
            if (text_byte == CH_NUL)
            begin
                have_char       = 1'b1;
                char_tok.kind   = stt_pkg::KIND_END;
                char_tok.length = 16'd0;
                // end of text: return every register to its reset value
                word_start_next = '0;
                pos_next        = '0;
                line_next       = 16'd1;
            end
            else if (text_byte == CH_SPACE || text_byte == CH_TAB || text_byte == CH_CR)
            begin
                have_char = 1'b0;
            end
            else if (text_byte == CH_LF)
            begin
                if (line_reg != 16'hFFFF)
                    line_next = line_reg + 16'd1;
            end
            else if (is_letter(text_byte) || text_byte == CH_UNDER)
            begin
                mode_next       = stt_pkg::MODE_IDENT;
                word_start_next = pos_reg;
                word_len_next   = 16'd1;
                kw_next         = (text_byte == 8'h66) ? KW_F : KW_DEAD;
            end
            else if (is_digit(text_byte))
            begin
                mode_next       = stt_pkg::MODE_NUMBER;
                word_start_next = pos_reg;
                word_len_next   = 16'd1;
            end
            else
            begin
                have_char = 1'b1;
            end
        end

        // word token goes first; the last flag marks the final token
        result.tok1 = char_tok;
        if (have_word)
        begin
            result.tok0      = word_tok;
            result.tok0.last = !have_char;
            result.count     = have_char ? 2'd2 : 2'd1;
        end
        else
        begin
            result.tok0  = char_tok;
            result.count = have_char ? 2'd1 : 2'd0;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/stt_token_fifo.sv */
// Small token queue that takes up to two tokens per cycle and hands out one.
`timescale 1ns / 1ps
`default_nettype none

module stt_token_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire stt_pkg::scan_out_t push,
    input  wire logic               pop,
    output stt_pkg::token_t         head,
    output logic                    not_empty,
    output logic [$clog2(stt_pkg::TOKEN_FIFO_DEPTH+1)-1:0] level
);

    localparam int DEPTH = stt_pkg::TOKEN_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    stt_pkg::token_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.tok0;
        if (push.count == 2'd2)
            mem[wr_ptr_plus1] <= push.tok1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign level     = count_reg;

endmodule

`default_nettype wire

/* rtl/core/source_text_tokenizer.sv */
// Top level of the streaming source text tokenizer.
`timescale 1ns / 1ps
`default_nettype none

// Streaming lexer: one text byte per input transaction, tokens out as output
// transactions. Whitespace (space, tab, CR, LF) is dropped and LF advances the
// line count; letters, underscore and digits form identifiers (the spelling
// "func" is reported as a keyword), digit runs form numbers, and every other
// nonzero byte is a one-byte symbol. A zero byte emits an end token and
// returns the scanner to its reset state. Each token carries kind, start
// offset, length and line; tlast marks the final token caused by one byte.
// Throughput is one byte per cycle while the input is not held off: the byte
// sits in an input register, the combinational scanner forms its tokens and
// writes them into a four-entry token queue. The input holds off only while
// the queue has fewer than two free entries, so a byte that ends a word and
// is itself a symbol or the end mark (two tokens) can make the input hold off.
module source_text_tokenizer #(
    parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [15:0] token_start, [31:16] token_length,
                                             // [47:32] line_number
    output logic [2:0]       m_axis_tuser,   // [2:0] token_kind
    output logic             m_axis_tlast    // last_of_run
);

    localparam int CNT_W = $clog2(stt_pkg::TOKEN_FIFO_DEPTH + 1);

    // Input register: one byte waiting for the scanner.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_accept;
    logic       proc_en;

    stt_pkg::scan_out_t scan_result;
    stt_pkg::scan_out_t push;
    stt_pkg::token_t    head;
    logic               not_empty;
    logic [CNT_W-1:0]   level;
    logic               pop;

    // Advance the scanner only when the queue can take two tokens.
    assign proc_en       = in_valid_reg
                           && (level <= CNT_W'(stt_pkg::TOKEN_FIFO_DEPTH - 2));
    assign s_axis_tready = !in_valid_reg || proc_en;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_accept)
            in_valid_reg <= 1'b1;
        else if (proc_en)
            in_valid_reg <= 1'b0;
    end

    // Payload holds while the byte waits; no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_byte_reg <= s_axis_tdata;
    end

    stt_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .proc_en   (proc_en),
        .text_byte (in_byte_reg),
        .result    (scan_result)
    );

    // Drop the scanner's tokens unless this cycle really processes a byte.
    always_comb
    begin
        push = scan_result;
        if (!proc_en)
            push.count = 2'd0;
    end

    assign pop = not_empty && m_axis_tready;

    stt_token_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .level     (level)
    );

    assign m_axis_tvalid = not_empty;
    assign m_axis_tdata  = {head.line, head.length, head.start};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;

    // The queue never holds more entries than it has.
    assert property (@(posedge clk) disable iff (!rst_n)
        level <= CNT_W'(stt_pkg::TOKEN_FIFO_DEPTH))
        else $error("token queue overflow");

    // An end token is always the final token of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == stt_pkg::KIND_END) |-> m_axis_tlast)
        else $error("end token without tlast");

    // A byte that is not processed stays in the input register unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !proc_en) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("pending byte lost");

    // An accepted byte is always held for the scanner in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_valid_reg)
        else $error("accepted byte not registered");

endmodule

`default_nettype wire
